// File: rtl/core/sha256_byte_stream_hasher_defines.svh
// assertion macros for the hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SBH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define SBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SBH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SBH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/sbh_pkg.sv
package sbh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // block-level work handed from front to back
  typedef struct packed {
    logic [511:0] block;
    logic         last;    // final block of the message: emit digest, reinit
  } job_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = 1;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/sbh_front.sv
// packs bytes into blocks and builds the padding blocks
module sbh_front (
  input  logic             clk,
  input  logic             rst,
  input  sbh_pkg::in_item_t in_item,
  input  logic             in_valid,
  output logic             in_ready,
  output sbh_pkg::job_t    job,
  output logic             job_valid,
  input  logic             job_ready
);

  typedef enum logic [3:0] {
    ST_BYTES = 4'b0001,
    ST_PAD   = 4'b0010,
    ST_EXTRA = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  localparam logic [7:0] PAD_BYTE_L = sbh_pkg::PAD_BYTE;

  state_t       state;
  logic [511:0] block;
  logic [5:0]   byte_position;
  logic [60:0]  byte_count;
  logic         pend_valid;
  logic         pend_eom;

  logic [63:0]  bits;
  logic [8:0]   sh;
  logic [511:0] len_field;

  assign bits      = {byte_count, 3'b000};
  assign sh        = {3'b000, ~byte_position} << 3;
  assign len_field = {448'd0, bits};

  // one input item at a time; a block push goes out when the queue has room
  assign in_ready  = (state == ST_BYTES) && !pend_valid;

  always_comb begin
    job       = '0;
    job_valid = 1'b0;
    unique case (state)
      ST_BYTES: begin
        job.block = block;
        job_valid = 1'b0;
      end
      ST_FLUSH: begin
        job.block = block;
        job_valid = 1'b1;
      end
      ST_PAD: begin
        // no room for the length after the pad byte: it goes in an extra block
        if (byte_position > 6'd55) begin
          job.block = block;
        end else begin
          job.block = block | len_field;
          job.last  = 1'b1;
        end
        job_valid = 1'b1;
      end
      ST_EXTRA: begin
        job.block = len_field;
        job.last  = 1'b1;
        job_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_BYTES;
      byte_position <= '0;
      byte_count    <= '0;
      pend_valid    <= 1'b0;
      pend_eom      <= 1'b0;
      block         <= '0;
    end else begin
      unique case (state)
        ST_BYTES: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
            if (pend_eom) begin
              // append the pad byte at the current position
              block <= block | ({504'd0, PAD_BYTE_L} << sh);
              state <= ST_PAD;
            end
          end else if (in_valid) begin
            if (in_item.has_byte) begin
              block         <= block | ({504'd0, in_item.data_byte} << sh);
              byte_position <= byte_position + 6'd1;
              byte_count    <= byte_count + 61'd1;
              if (byte_position == 6'd63) begin
                state <= ST_FLUSH;
              end
            end
            pend_eom   <= in_item.end_of_message;
            pend_valid <= in_item.end_of_message;
          end
        end
        ST_FLUSH: begin
          if (job_ready) begin
            block <= '0;
            state <= ST_BYTES;
          end
        end
        ST_PAD: begin
          if (byte_position > 6'd55) begin
            if (job_ready) begin
              block         <= '0;
              byte_position <= '0;
              state         <= ST_EXTRA;
            end
          end else if (job_ready) begin
            block         <= '0;
            byte_position <= '0;
            byte_count    <= '0;
            state         <= ST_BYTES;
          end
        end
        ST_EXTRA: begin
          if (job_ready) begin
            byte_count <= '0;
            state      <= ST_BYTES;
          end
        end
        default: state <= ST_BYTES;
      endcase
    end
  end

endmodule

// File: rtl/core/sbh_queue.sv
// short block queue between front and back
module sbh_queue (
  input  logic          clk,
  input  logic          rst,
  input  sbh_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output sbh_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_ready
);

  localparam logic [sbh_pkg::QIDX_W:0] FULL_COUNT = sbh_pkg::QDEPTH[sbh_pkg::QIDX_W:0];

  sbh_pkg::job_t                   mem [sbh_pkg::QDEPTH];
  logic [sbh_pkg::QIDX_W-1:0]      wr_ptr;
  logic [sbh_pkg::QIDX_W-1:0]      rd_ptr;
  logic [sbh_pkg::QIDX_W:0]        count;
  logic                            push;
  logic                            pop;

  assign wr_ready = count != FULL_COUNT;
  assign rd_valid = count != '0;
  assign rd_job   = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{sbh_pkg::QIDX_W{1'b0}}, push} - {{sbh_pkg::QIDX_W{1'b0}}, pop};
    end
  end

endmodule

// File: rtl/core/sbh_back.sv
// 64-round compression, one round per cycle, then digest words out after a message's final block
module sbh_back (
  input  logic             clk,
  input  logic             rst,
  input  sbh_pkg::job_t    job,
  input  logic             job_valid,
  output logic             job_ready,
  output sbh_pkg::out_item_t out_item,
  output logic             out_valid,
  input  logic             out_ready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t       state;
  logic [31:0]  hash [8];
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   rnd;
  logic         last;
  logic [2:0]   widx;

  logic [31:0]  s0, s1, wnew, ch, mj, bs0, bs1, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  assign s0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign ch   = (e & f) ^ (~e & g);
  assign mj   = (a & b) ^ (a & c) ^ (b & c);
  assign bs0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign bs1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign t1   = h + bs1 + ch + sbh_pkg::round_k(rnd) + w[0];
  assign t2   = bs0 + mj;

  assign job_ready = state == ST_IDLE;
  assign out_valid = state == ST_EMIT;
  assign out_item.digest_word = hash[widx];
  assign out_item.word_index  = widx;
  assign out_item.last_word   = widx == 3'd7;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= job.block[511 - 32*i -: 32];
          end
          {a, b, c, d} <= {hash[0], hash[1], hash[2], hash[3]};
          {e, f, g, h} <= {hash[4], hash[5], hash[6], hash[7]};
          last <= job.last;
        end
      end
      ST_ROUND: begin
        // message schedule slides one word per round
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= wnew;
        h <= g; g <= f; f <= e; e <= d + t1;
        d <= c; c <= b; b <= a; a <= t1 + t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
      widx  <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sbh_pkg::INIT_HASH[255 - 32*i -: 32];
    end else begin
      unique case (state)
        ST_IDLE: begin
          rnd <= '0;
          if (job_valid) state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
          hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
          widx  <= '0;
          state <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= sbh_pkg::INIT_HASH[255 - 32*i -: 32];
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream.
// input channel: in_item (data_byte, has_byte, end_of_message) with in_valid /
// in_ready. an item with has_byte packs its byte big-endian into the block;
// end_of_message pads the message and yields the digest.
// output channel: out_item (digest_word, word_index, last_word) with out_valid /
// out_ready, eight beats per message, H0 first, last_word on the eighth.
// bytes are taken one per cycle while in_ready is high; once a block has its 64th
// byte, the front hands the block to a two-entry queue. the back end runs one
// round per cycle, 64 rounds per block; the queue keeps the rounds busy.
// end of message: in_ready stays low while one or two padding blocks go out.
// while the receiver stalls the back end holds the digest; the queue fills and
// then in_ready drops. reset is synchronous and returns to the initial hash
// values with empty block and queue.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  sbh_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output sbh_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);

  sbh_pkg::job_t f_job;
  logic          f_valid;
  logic          f_ready;
  sbh_pkg::job_t b_job;
  logic          b_valid;
  logic          b_ready;

  sbh_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  sbh_queue u_queue (
    .clk(clk), .rst(rst), .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(b_job), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  sbh_back u_back (
    .clk(clk), .rst(rst), .job(b_job), .job_valid(b_valid), .job_ready(b_ready),
    .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
  );

  `SBH_ASSERT_IMPL(a_last_idx, clk, rst, out_valid, out_item.last_word == (out_item.word_index == 3'd7))
  `SBH_ASSERT_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !out_item.last_word, out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1)
  `SBH_ASSERT_IMPL(a_no_pop_busy, clk, rst, out_valid, !b_ready)

endmodule
